// ===== hw/rtl/tcn_pkg.sv =====
// Shared types and constants of the two-compartment neuron step block.
// No dependencies; every other file of the block imports this package.
package tcn_pkg;

	localparam int VAL_W      = 16;  // Q8.8 values and weights, unsigned Q0.16 rates
	localparam int TS_W       = 32;  // time stamp
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 48;

	// Shared multiplier: signed 36 x signed 17 bit operands
	localparam int MUL_A_W = 36;
	localparam int MUL_B_W = 17;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WEIGHT_BASAL      = 3'd0,
		CFG_WEIGHT_BASAL_REC  = 3'd1,
		CFG_WEIGHT_APICAL     = 3'd2,
		CFG_WEIGHT_APICAL_REC = 3'd3,
		CFG_WEIGHT_SOMA       = 3'd4,
		CFG_COUPLING_RATIO    = 3'd5,
		CFG_SPIKE_THRESHOLD   = 3'd6,
		CFG_DECAY_RATES       = 3'd7
	} cfg_idx_t;

endpackage

// ===== hw/rtl/tcn_if.sv =====
// Word channels of the neuron step block: the input step word and the result word.
// Depends on tcn_pkg for field widths.
interface tcn_in_if;
	import tcn_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [VAL_W-1:0] basal_input;
	logic signed [VAL_W-1:0] apical_input;
	logic signed [VAL_W-1:0] recurrent_input;
	logic [TS_W-1:0]         time_stamp;

	modport source (output valid, basal_input, apical_input, recurrent_input, time_stamp,
		input ready);
	modport sink (input valid, basal_input, apical_input, recurrent_input, time_stamp,
		output ready);
endinterface

interface tcn_out_if;
	import tcn_pkg::*;

	logic                    valid;
	logic                    ready;
	logic                    spike;
	logic [TS_W-1:0]         last_spike_time;
	logic signed [VAL_W-1:0] soma_potential;

	modport source (output valid, spike, last_spike_time, soma_potential, input ready);
	modport sink (input valid, spike, last_spike_time, soma_potential, output ready);
endinterface

// ===== hw/rtl/two_compartment_neuron_step.sv =====
// Top level of the two-compartment neuron step: sequencer, state and configuration.
// Depends on tcn_pkg, tcn_if (channels), tcn_mul and tcn_sig_rom.
//
//  channel     dir  handshake            word
//  step_in     in   valid/ready          basal, apical, recurrent input, time stamp
//  step_out    out  valid/ready          spike, last spike time, soma potential
//  cfg         in   cfg_we (no ready)    cfg_index, cfg_wdata
//
// A step word is taken in the idle state and passes through fifteen sequencer steps through
// the one shared multiplier, whose product is registered, and the result hand-off; only then
// is a new word taken. The result sits in its own register, so the next word is accepted
// while the previous result waits; the hand-off step waits only if that register is still full.
// Reset clears the neuron state and loads the register defaults; it is asynchronous.
module two_compartment_neuron_step #(
	parameter int SIGMOID_SLOPE_Q8    = 256,
	parameter int SIGMOID_TABLE_DEPTH = 256
) (
	input  logic                               clk,
	input  logic                               arst_n,
	tcn_in_if.sink                             step_in,
	tcn_out_if.source                          step_out,
	input  logic                               cfg_we,
	input  logic [tcn_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tcn_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
	import tcn_pkg::*;

	localparam int ADDR_W = $clog2(SIGMOID_TABLE_DEPTH);

	typedef enum logic [16:0] {
		ST_IDLE = 17'b00000000000000001,
		ST_BW   = 17'b00000000000000010,
		ST_BR   = 17'b00000000000000100,
		ST_AW   = 17'b00000000000001000,
		ST_BL   = 17'b00000000000010000,
		ST_AR   = 17'b00000000000100000,
		ST_CP   = 17'b00000000001000000,
		ST_AL   = 17'b00000000010000000,
		ST_SD   = 17'b00000000100000000,
		ST_SC   = 17'b00000001000000000,
		ST_SI   = 17'b00000010000000000,
		ST_SR   = 17'b00000100000000000,
		ST_GT   = 17'b00001000000000000,
		ST_GW   = 17'b00010000000000000,
		ST_SL   = 17'b00100000000000000,
		ST_UP   = 17'b01000000000000000,
		ST_OUT  = 17'b10000000000000000
	} state_t;

	function automatic logic signed [VAL_W-1:0] sat16(input logic signed [29:0] x);
		if (x > 30'sd32767) begin
			return 16'sh7fff;
		end else if (x < -30'sd32768) begin
			return 16'sh8000;
		end
		return x[VAL_W-1:0];
	endfunction

	state_t state_q;

	// Configuration registers
	logic signed [VAL_W-1:0] wb_q, wbr_q, wa_q, war_q, ws_q, thr_q;
	logic [VAL_W-1:0]        ratio_q;
	logic [3*VAL_W-1:0]      rates_q;

	// Neuron state
	logic signed [VAL_W-1:0] vb_q, va_q, u_q;
	logic [TS_W-1:0]         spike_ts_q;
	logic                    fire_q;

	// Captured step word
	logic signed [VAL_W-1:0] b_in_q, a_in_q, rec_q;
	logic [TS_W-1:0]         ts_q;

	// Datapath
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [MUL_P_W-1:0] prod_q;
	logic signed [35:0]        prod36;
	logic signed [33:0]        acc_q;
	logic signed [35:0]        diff_q;
	logic signed [VAL_W-1:0]   p_sel;
	logic signed [29:0]        leak_sum;
	logic signed [VAL_W-1:0]   leak_new;
	logic signed [35:0]        t_full;
	logic signed [11:0]        t_clamp;
	logic [11:0]               t_off;
	logic [12:0]               idx_raw;
	logic [ADDR_W-1:0]         rom_addr;
	logic [VAL_W-1:0]          gate_z;

	// Result register
	logic                    out_valid_q;
	logic                    out_spike_q;
	logic [TS_W-1:0]         out_ts_q;
	logic signed [VAL_W-1:0] out_soma_q;

	tcn_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (prod_q)
	);

	tcn_sig_rom #(
		.SIGMOID_TABLE_DEPTH (SIGMOID_TABLE_DEPTH)
	) u_sig_rom (
		.clk    (clk),
		.rd_en  (state_q == ST_SR),
		.addr   (rom_addr),
		.data_q (gate_z)
	);

	assign prod36 = $signed(prod_q[35:0]);

	// Sigmoid argument: slope-scaled apical potential, clamped to the table span
	assign t_full = prod36 >>> 8;
	always_comb begin
		if (t_full < -36'sd2048) begin
			t_clamp = 12'sh800;
		end else if (t_full > 36'sd2047) begin
			t_clamp = 12'sd2047;
		end else begin
			t_clamp = t_full[11:0];
		end
	end
	assign t_off = {~t_clamp[11], t_clamp[10:0]};

	assign idx_raw = prod_q[24:12];
	always_comb begin
		if (idx_raw >= 13'(SIGMOID_TABLE_DEPTH)) begin
			rom_addr = ADDR_W'(SIGMOID_TABLE_DEPTH - 1);
		end else begin
			rom_addr = idx_raw[ADDR_W-1:0];
		end
	end

	// Leak: potential plus the rate-scaled difference, floored by the arithmetic shift
	always_comb begin
		unique case (state_q)
			ST_AR:   p_sel = vb_q;
			ST_SD:   p_sel = va_q;
			default: p_sel = u_q;
		endcase
	end
	assign leak_sum = 30'(p_sel) + 30'($signed(prod_q[MUL_P_W-1:24]));
	assign leak_new = sat16(leak_sum);

	// Operand selection for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_BW: begin
				mul_a = MUL_A_W'(wb_q);
				mul_b = MUL_B_W'(b_in_q);
			end
			ST_BR: begin
				mul_a = MUL_A_W'(wbr_q);
				mul_b = MUL_B_W'(rec_q);
			end
			ST_AW: begin
				mul_a = MUL_A_W'(wa_q);
				mul_b = MUL_B_W'(a_in_q);
			end
			ST_BL: begin
				mul_a = diff_q;
				mul_b = $signed({1'b0, rates_q[VAL_W-1:0]});
			end
			ST_AR: begin
				mul_a = MUL_A_W'(war_q);
				mul_b = MUL_B_W'(rec_q);
			end
			ST_CP: begin
				mul_a = MUL_A_W'(vb_q) - MUL_A_W'(u_q);
				mul_b = $signed({1'b0, ratio_q});
			end
			ST_AL: begin
				mul_a = diff_q;
				mul_b = $signed({1'b0, rates_q[2*VAL_W-1:VAL_W]});
			end
			ST_SD: begin
				mul_a = MUL_A_W'(ws_q);
				mul_b = MUL_B_W'(b_in_q);
			end
			ST_SC: begin
				mul_a = MUL_A_W'(va_q);
				mul_b = $signed(MUL_B_W'(SIGMOID_SLOPE_Q8));
			end
			ST_SI: begin
				mul_a = $signed(MUL_A_W'(t_off));
				mul_b = $signed(MUL_B_W'(SIGMOID_TABLE_DEPTH));
			end
			ST_GT: begin
				mul_a = MUL_A_W'(acc_q);
				mul_b = $signed({1'b0, gate_z});
			end
			ST_SL: begin
				mul_a = diff_q;
				mul_b = $signed({1'b0, rates_q[3*VAL_W-1:2*VAL_W]});
			end
			default: ;
		endcase
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wb_q    <= 16'sd256;
			wbr_q   <= '0;
			wa_q    <= 16'sd256;
			war_q   <= '0;
			ws_q    <= '0;
			ratio_q <= 16'd256;
			thr_q   <= 16'sd256;
			rates_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_WEIGHT_BASAL:      wb_q    <= cfg_wdata[VAL_W-1:0];
				CFG_WEIGHT_BASAL_REC:  wbr_q   <= cfg_wdata[VAL_W-1:0];
				CFG_WEIGHT_APICAL:     wa_q    <= cfg_wdata[VAL_W-1:0];
				CFG_WEIGHT_APICAL_REC: war_q   <= cfg_wdata[VAL_W-1:0];
				CFG_WEIGHT_SOMA:       ws_q    <= cfg_wdata[VAL_W-1:0];
				CFG_COUPLING_RATIO:    ratio_q <= cfg_wdata[VAL_W-1:0];
				CFG_SPIKE_THRESHOLD:   thr_q   <= cfg_wdata[VAL_W-1:0];
				CFG_DECAY_RATES:       rates_q <= cfg_wdata[3*VAL_W-1:0];
				default: ;
			endcase
		end
	end

	assign step_in.ready = (state_q == ST_IDLE);

	// Captured word and working registers
	always_ff @(posedge clk) begin
		if (step_in.valid && step_in.ready) begin
			b_in_q <= step_in.basal_input;
			a_in_q <= step_in.apical_input;
			rec_q  <= step_in.recurrent_input;
			ts_q   <= step_in.time_stamp;
		end
		case (state_q)
			ST_BR, ST_BL, ST_AL: acc_q <= 34'(prod36);
			ST_SC:               acc_q <= acc_q + 34'(prod36);
			default: ;
		endcase
		case (state_q)
			ST_AW:   diff_q <= 36'(acc_q) + prod36 - (36'(vb_q) <<< 8);
			ST_CP:   diff_q <= 36'(acc_q) + prod36 - (36'(va_q) <<< 8);
			ST_GW:   diff_q <= $signed(prod_q[51:16]) - (36'(u_q) <<< 8);
			default: ;
		endcase
	end

	// Sequencer and neuron state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			vb_q       <= '0;
			va_q       <= '0;
			u_q        <= '0;
			spike_ts_q <= '0;
			fire_q     <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (step_in.valid) begin
						state_q <= ST_BW;
					end
				end
				ST_BW: state_q <= ST_BR;
				ST_BR: state_q <= ST_AW;
				ST_AW: state_q <= ST_BL;
				ST_BL: state_q <= ST_AR;
				ST_AR: begin
					vb_q    <= leak_new;
					state_q <= ST_CP;
				end
				ST_CP: state_q <= ST_AL;
				ST_AL: state_q <= ST_SD;
				ST_SD: begin
					va_q    <= leak_new;
					state_q <= ST_SC;
				end
				ST_SC: state_q <= ST_SI;
				ST_SI: state_q <= ST_SR;
				ST_SR: state_q <= ST_GT;
				ST_GT: state_q <= ST_GW;
				ST_GW: state_q <= ST_SL;
				ST_SL: state_q <= ST_UP;
				ST_UP: begin
					u_q    <= leak_new;
					fire_q <= (leak_new >= thr_q);
					if (leak_new >= thr_q) begin
						spike_ts_q <= ts_q;
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_valid_q || step_out.ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Result word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_OUT && (!out_valid_q || step_out.ready)) begin
			out_valid_q <= 1'b1;
		end else if (step_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && (!out_valid_q || step_out.ready)) begin
			out_spike_q <= fire_q;
			out_ts_q    <= spike_ts_q;
			out_soma_q  <= u_q;
		end
	end

	assign step_out.valid           = out_valid_q;
	assign step_out.spike           = out_spike_q;
	assign step_out.last_spike_time = out_ts_q;
	assign step_out.soma_potential  = out_soma_q;

endmodule

// ===== hw/rtl/tcn_mul.sv =====
// Shared signed multiplier of the neuron step datapath, product registered.
// Depends on tcn_pkg for operand widths.
module tcn_mul (
	input  logic                                 clk,
	input  logic signed [tcn_pkg::MUL_A_W-1:0]   a,
	input  logic signed [tcn_pkg::MUL_B_W-1:0]   b,
	output logic signed [tcn_pkg::MUL_P_W-1:0]   p_q
);
	import tcn_pkg::*;

	always_ff @(posedge clk) begin
		p_q <= MUL_P_W'(a) * MUL_P_W'(b);
	end

endmodule

// ===== hw/rtl/tcn_sig_rom.sv =====
// Sigmoid gate table, built at elaboration from the bin centers, with a registered read.
// Depends on tcn_pkg for the entry width.
module tcn_sig_rom #(
	parameter int SIGMOID_TABLE_DEPTH = 256
) (
	input  logic                                   clk,
	input  logic                                   rd_en,
	input  logic [$clog2(SIGMOID_TABLE_DEPTH)-1:0] addr,
	output logic [tcn_pkg::VAL_W-1:0]              data_q
);
	import tcn_pkg::*;

	localparam longint unsigned Q30_ONE = 64'd1 << 30;

	// Six squarings in Q30 raise the series value to the 64th power.
	function automatic longint unsigned sq6_q30(input longint unsigned p0);
		longint unsigned p;
		p = p0;
		for (int i = 0; i < 6; i++) begin
			p = (p * p) >> 30;
		end
		return p;
	endfunction

	logic [VAL_W-1:0] rom [SIGMOID_TABLE_DEPTH];

	// Sigmoid at the center of bin g, unsigned Q0.16. e^-|c| is a fourth-order
	// series at |c|/64 raised to the 64th power, all in Q30.
	for (genvar g = 0; g < SIGMOID_TABLE_DEPTH; g++) begin : g_entry
		localparam longint          C16 =
			((2 * longint'(g) + 1) * 64'sd524288) / SIGMOID_TABLE_DEPTH - 64'sd524288;
		localparam longint unsigned MAG = (C16 < 0) ? longint'(-C16) : longint'(C16);
		localparam longint unsigned W   = (MAG << 14) >> 6;
		localparam longint unsigned W2  = (W * W) >> 30;
		localparam longint unsigned W3  = (W2 * W) >> 30;
		localparam longint unsigned W4  = (W3 * W) >> 30;
		localparam longint unsigned P0  = Q30_ONE - W + W2 / 2 - W3 / 6 + W4 / 24;
		localparam longint unsigned E   = sq6_q30(P0);
		localparam longint unsigned R   = (C16 >= 0) ? (Q30_ONE << 16) / (Q30_ONE + E)
			: (E << 16) / (Q30_ONE + E);
		localparam logic [VAL_W-1:0] ENTRY = (R > 64'd65535) ? 16'hffff : VAL_W'(R);
		assign rom[g] = ENTRY;
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			data_q <= rom[addr];
		end
	end

endmodule
